// ===== design/csm_pkg.sv =====
// Shared constants, types and helpers of the collinear segment merge core.
package csm_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int COORD_BITS_DEF   = 24;
   localparam int TOL_BITS         = 16;
   localparam int MERGE_BITS       = 6;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [TOL_BITS-1:0]   TOL_RESET = 16'd66;
   localparam logic [MERGE_BITS-1:0] MERGE_MAX = 6'd63;
   localparam logic                  CSR_IDX_TOLERANCE = 1'b0;

   typedef struct packed {
      logic valid;
      logic finish;
      logic vertical;
   } q_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/csm_if.sv =====
// Request and result channel interfaces of the collinear segment merge core.
interface csm_req_if #(parameter int CB = 24) ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic signed [CB-1:0] start_x;
   logic signed [CB-1:0] start_y;
   logic signed [CB-1:0] end_x;
   logic signed [CB-1:0] end_y;

   modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface csm_rsp_if #(parameter int CB = 24) ();
   logic                 valid;
   logic                 ready;
   logic signed [CB-1:0] out_start_x;
   logic signed [CB-1:0] out_start_y;
   logic signed [CB-1:0] out_end_x;
   logic signed [CB-1:0] out_end_y;
   logic                 segment_valid;
   logic                 last_segment;
   logic [5:0]           merge_total;
   logic                 dropped_flag;

   modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y,
                   segment_valid, last_segment, merge_total, dropped_flag, input ready);
   modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y,
                 segment_valid, last_segment, merge_total, dropped_flag, output ready);
endinterface

// ===== design/csm_front.sv =====
// Request intake: decode, classify and queue requests for the engine.
module csm_front
   import csm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   csm_req_if.sink                 req_bus,
   output q_ctl_type               q_ctl,
   output logic signed [COORD_BITS-1:0] q_ax,
   output logic signed [COORD_BITS-1:0] q_ay,
   output logic signed [COORD_BITS-1:0] q_bx,
   output logic signed [COORD_BITS-1:0] q_by,
   output logic signed [COORD_BITS:0]   q_dx,
   output logic signed [COORD_BITS:0]   q_dy,
   input  logic                    q_pop
);
   localparam int CB = COORD_BITS;
   localparam int FW = 2 + 4 * CB + 2 * (CB + 1);

   logic [FW-1:0] ent_ff [2];
   logic [FW-1:0] ent_in;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, pop;
   logic signed [CB:0] dx, dy;
   logic [FW-1:0] head;

   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = q_pop && (cnt_ff != 2'd0);

   always_comb begin
      dx = (CB+1)'(req_bus.end_x) - (CB+1)'(req_bus.start_x);
      dy = (CB+1)'(req_bus.end_y) - (CB+1)'(req_bus.start_y);
      ent_in = {req_bus.command, (dx == '0), req_bus.start_x, req_bus.start_y,
                req_bus.end_x, req_bus.end_y, dx, dy};
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

   assign head = ent_ff[rd_ptr_ff];

   always_comb begin
      q_ctl.valid    = (cnt_ff != 2'd0);
      q_ctl.finish   = head[FW-1];
      q_ctl.vertical = head[FW-2];
      q_ax = $signed(head[2*(CB+1)+4*CB-1 -: CB]);
      q_ay = $signed(head[2*(CB+1)+3*CB-1 -: CB]);
      q_bx = $signed(head[2*(CB+1)+2*CB-1 -: CB]);
      q_by = $signed(head[2*(CB+1)+CB-1 -: CB]);
      q_dx = $signed(head[2*(CB+1)-1 -: CB+1]);
      q_dy = $signed(head[CB:0]);
   end

endmodule

// ===== design/csm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module csm_div
   import csm_pkg::*;
#(
   parameter int NW = 41,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output div_stat_type  stat,
   output logic [NW-1:0] quo
);
   localparam int CNW = $clog2(NW + 1);

   logic [DW-1:0]  rem_ff, rem_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DW:0]    shifted, diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo = quo_ff;

endmodule

// ===== design/csm_back.sv =====
// Merge engine: segment table, line fitting, pair scan, compaction and emission.
module csm_back
   import csm_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [TOL_BITS-1:0]     tolerance,
   input  q_ctl_type               q_ctl,
   input  logic signed [COORD_BITS-1:0] q_ax,
   input  logic signed [COORD_BITS-1:0] q_ay,
   input  logic signed [COORD_BITS-1:0] q_bx,
   input  logic signed [COORD_BITS-1:0] q_by,
   input  logic signed [COORD_BITS:0]   q_dx,
   input  logic signed [COORD_BITS:0]   q_dy,
   output logic                    q_pop,
   csm_rsp_if.source               rsp_bus
);
   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int EW = 4 * CB + 65;
   localparam int NW = CB + 17;
   localparam int DW = CB + 1;
   localparam int PW = CB + 32;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_CSTART = 5'd1;
   localparam logic [4:0] ST_CDIV   = 5'd2;
   localparam logic [4:0] ST_CMUL   = 5'd3;
   localparam logic [4:0] ST_CB     = 5'd4;
   localparam logic [4:0] ST_CWR    = 5'd5;
   localparam logic [4:0] ST_SINIT  = 5'd6;
   localparam logic [4:0] ST_SRDI   = 5'd7;
   localparam logic [4:0] ST_SLATI  = 5'd8;
   localparam logic [4:0] ST_SRDJ   = 5'd9;
   localparam logic [4:0] ST_SCMP   = 5'd10;
   localparam logic [4:0] ST_KRD    = 5'd11;
   localparam logic [4:0] ST_KWR    = 5'd12;
   localparam logic [4:0] ST_MPREP  = 5'd13;
   localparam logic [4:0] ST_ERD    = 5'd14;
   localparam logic [4:0] ST_EOUT   = 5'd15;
   localparam logic [4:0] ST_EEMPTY = 5'd16;

   logic [EW-1:0] mem [MAX_SEGMENTS];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [4:0]      state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [MERGE_BITS-1:0] merges_ff, merges_in;
   logic            ovf_ff, ovf_in;
   logic            from_merge_ff, from_merge_in;
   logic [IW-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in, w_ff, w_in;
   logic signed [CB-1:0] wax_ff, wax_in, way_ff, way_in, wbx_ff, wbx_in, wby_ff, wby_in;
   logic signed [CB:0]   wdx_ff, wdx_in, wdy_ff, wdy_in;
   logic            wvert_ff, wvert_in;
   logic signed [31:0] m_ff, m_in, b_ff, b_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [EW-1:0]   pi_ff, pi_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [CB-1:0] ro_ax_ff, ro_ax_in, ro_ay_ff, ro_ay_in;
   logic signed [CB-1:0] ro_bx_ff, ro_bx_in, ro_by_ff, ro_by_in;
   logic            ro_seg_ff, ro_seg_in, ro_last_ff, ro_last_in, ro_drop_ff, ro_drop_in;
   logic [MERGE_BITS-1:0] ro_mt_ff, ro_mt_in;
   logic            out_free;

   div_stat_type    div_stat;
   logic            div_start;
   logic [NW-1:0]   div_quo;
   logic [DW-1:0]   dx_mag, dy_mag;
   logic            q_neg;
   logic signed [NW:0] q_signed;

   logic signed [CB-1:0] pax, pay, pbx, pby, qax, qay, qbx, qby;
   logic signed [31:0]   pm, pb, qm, qb;
   logic                 pvert, qvert;
   logic signed [32:0]   dm, db;
   logic [32:0]          adm, adb;
   logic signed [CB-1:0] pmax, pmin, qmax, qmin;
   logic                 can_merge;
   logic signed [CB-1:0] xs [4];
   logic signed [CB-1:0] ys [4];
   logic [1:0]           lo, hi;
   logic signed [PW-1:0] t_round;
   logic signed [63:0]   b_full;
   logic                 last_k;

   csm_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({dy_mag, 16'b0}),
      .den   (dx_mag),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      dx_mag = wdx_ff[CB] ? DW'(-wdx_ff) : DW'(wdx_ff);
      dy_mag = wdy_ff[CB] ? DW'(-wdy_ff) : DW'(wdy_ff);
      q_neg  = wdx_ff[CB] ^ wdy_ff[CB];
      q_signed = q_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      t_round = prod_ff[PW-1] ? prod_ff + PW'(255) : prod_ff;
      b_full  = (64'(way_ff) <<< 8) - 64'(t_round >>> 8);

      pax = $signed(pi_ff[CB-1:0]);
      pay = $signed(pi_ff[2*CB-1 -: CB]);
      pbx = $signed(pi_ff[3*CB-1 -: CB]);
      pby = $signed(pi_ff[4*CB-1 -: CB]);
      pm  = $signed(pi_ff[4*CB+31 -: 32]);
      pb  = $signed(pi_ff[4*CB+63 -: 32]);
      pvert = pi_ff[EW-1];
      qax = $signed(rd_data_ff[CB-1:0]);
      qay = $signed(rd_data_ff[2*CB-1 -: CB]);
      qbx = $signed(rd_data_ff[3*CB-1 -: CB]);
      qby = $signed(rd_data_ff[4*CB-1 -: CB]);
      qm  = $signed(rd_data_ff[4*CB+31 -: 32]);
      qb  = $signed(rd_data_ff[4*CB+63 -: 32]);
      qvert = rd_data_ff[EW-1];

      dm  = 33'(pm) - 33'(qm);
      db  = 33'(pb) - 33'(qb);
      adm = dm[32] ? 33'(-dm) : 33'(dm);
      adb = db[32] ? 33'(-db) : 33'(db);
      pmax = (pax > pbx) ? pax : pbx;
      pmin = (pax < pbx) ? pax : pbx;
      qmax = (qax > qbx) ? qax : qbx;
      qmin = (qax < qbx) ? qax : qbx;
      can_merge = !pvert && !qvert && (adm < 33'(tolerance)) && (adb < 33'(tolerance))
                  && (pmax >= qmin) && (qmax >= pmin);

      xs[0] = pax; xs[1] = pbx; xs[2] = qax; xs[3] = qbx;
      ys[0] = pay; ys[1] = pby; ys[2] = qay; ys[3] = qby;
      lo = 2'd0;
      hi = 2'd0;
      for (int n = 1; n < 4; n++) begin
         if ((xs[n] < xs[lo]) || ((xs[n] == xs[lo]) && (ys[n] < ys[lo]))) begin
            lo = 2'(n);
         end
         if ((xs[hi] < xs[n]) || ((xs[hi] == xs[n]) && (ys[hi] < ys[n]))) begin
            hi = 2'(n);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_k   = (CW'(k_ff) + CW'(1)) == cnt_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      merges_in     = merges_ff;
      ovf_in        = ovf_ff;
      from_merge_in = from_merge_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; w_in = w_ff;
      wax_in = wax_ff; way_in = way_ff; wbx_in = wbx_ff; wby_in = wby_ff;
      wdx_in = wdx_ff; wdy_in = wdy_ff; wvert_in = wvert_ff;
      m_in = m_ff; b_in = b_ff; prod_in = prod_ff; pi_in = pi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ro_ax_in = ro_ax_ff; ro_ay_in = ro_ay_ff; ro_bx_in = ro_bx_ff; ro_by_in = ro_by_ff;
      ro_seg_in = ro_seg_ff; ro_last_in = ro_last_ff; ro_drop_in = ro_drop_ff;
      ro_mt_in = ro_mt_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = w_ff;
      wr_data   = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_ctl.valid) begin
               q_pop = 1'b1;
               if (q_ctl.finish) begin
                  state_in = ST_SINIT;
               end else if (cnt_ff < CW'(MAX_SEGMENTS)) begin
                  wax_in = q_ax; way_in = q_ay; wbx_in = q_bx; wby_in = q_by;
                  wdx_in = q_dx; wdy_in = q_dy; wvert_in = q_ctl.vertical;
                  from_merge_in = 1'b0;
                  state_in = ST_CSTART;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_CSTART: begin
            if (wvert_ff) begin
               m_in = '0;
               b_in = '0;
               state_in = ST_CWR;
            end else begin
               div_start = 1'b1;
               state_in  = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_stat.done) begin
               m_in = sat32(64'(q_signed));
               state_in = ST_CMUL;
            end
         end
         ST_CMUL: begin
            prod_in  = m_ff * wax_ff;
            state_in = ST_CB;
         end
         ST_CB: begin
            b_in     = sat32(b_full);
            state_in = ST_CWR;
         end
         ST_CWR: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_ff[IW-1:0];
            wr_data  = {wvert_ff, b_ff, m_ff, wby_ff, wbx_ff, way_ff, wax_ff};
            cnt_in   = cnt_ff + CW'(1);
            state_in = from_merge_ff ? ST_SINIT : ST_IDLE;
         end
         ST_SINIT: begin
            i_in = '0;
            k_in = '0;
            if (cnt_ff == '0) begin
               state_in = ST_EEMPTY;
            end else if (cnt_ff < CW'(2)) begin
               state_in = ST_ERD;
            end else begin
               state_in = ST_SRDI;
            end
         end
         ST_SRDI: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_SLATI;
         end
         ST_SLATI: begin
            pi_in    = rd_data_ff;
            j_in     = i_ff + IW'(1);
            state_in = ST_SRDJ;
         end
         ST_SRDJ: begin
            rd_en    = 1'b1;
            rd_addr  = j_ff;
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (can_merge) begin
               wax_in = xs[lo]; way_in = ys[lo];
               wbx_in = xs[hi]; wby_in = ys[hi];
               if (merges_ff != MERGE_MAX) begin
                  merges_in = merges_ff + MERGE_BITS'(1);
               end
               k_in = '0;
               w_in = '0;
               state_in = ST_KRD;
            end else if ((CW'(j_ff) + CW'(1)) < cnt_ff) begin
               j_in = j_ff + IW'(1);
               state_in = ST_SRDJ;
            end else if ((CW'(i_ff) + CW'(2)) < cnt_ff) begin
               i_in = i_ff + IW'(1);
               state_in = ST_SRDI;
            end else begin
               k_in = '0;
               state_in = ST_ERD;
            end
         end
         ST_KRD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_KWR;
         end
         ST_KWR: begin
            if ((k_ff != i_ff) && (k_ff != j_ff)) begin
               wr_en = 1'b1;
               w_in  = w_ff + IW'(1);
            end
            if (last_k) begin
               cnt_in   = CW'(w_in);
               state_in = ST_MPREP;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = ST_KRD;
            end
         end
         ST_MPREP: begin
            wdx_in = (CB+1)'(wbx_ff) - (CB+1)'(wax_ff);
            wdy_in = (CB+1)'(wby_ff) - (CB+1)'(way_ff);
            wvert_in = (wbx_ff == wax_ff);
            from_merge_in = 1'b1;
            state_in = ST_CSTART;
         end
         ST_ERD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_EOUT;
         end
         ST_EOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ro_ax_in = qax; ro_ay_in = qay; ro_bx_in = qbx; ro_by_in = qby;
               ro_seg_in  = 1'b1;
               ro_last_in = last_k;
               ro_mt_in   = last_k ? merges_ff : '0;
               ro_drop_in = ovf_ff;
               if (last_k) begin
                  cnt_in    = '0;
                  merges_in = '0;
                  ovf_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = ST_ERD;
               end
            end
         end
         ST_EEMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ro_ax_in = '0; ro_ay_in = '0; ro_bx_in = '0; ro_by_in = '0;
               ro_seg_in  = 1'b0;
               ro_last_in = 1'b1;
               ro_mt_in   = '0;
               ro_drop_in = ovf_ff;
               merges_in  = '0;
               ovf_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         merges_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         merges_ff    <= merges_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      from_merge_ff <= from_merge_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; w_ff <= w_in;
      wax_ff <= wax_in; way_ff <= way_in; wbx_ff <= wbx_in; wby_ff <= wby_in;
      wdx_ff <= wdx_in; wdy_ff <= wdy_in; wvert_ff <= wvert_in;
      m_ff <= m_in; b_ff <= b_in; prod_ff <= prod_in; pi_ff <= pi_in;
      ro_ax_ff <= ro_ax_in; ro_ay_ff <= ro_ay_in; ro_bx_ff <= ro_bx_in; ro_by_ff <= ro_by_in;
      ro_seg_ff <= ro_seg_in; ro_last_ff <= ro_last_in; ro_drop_ff <= ro_drop_in;
      ro_mt_ff <= ro_mt_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_start_x   = ro_ax_ff;
   assign rsp_bus.out_start_y   = ro_ay_ff;
   assign rsp_bus.out_end_x     = ro_bx_ff;
   assign rsp_bus.out_end_y     = ro_by_ff;
   assign rsp_bus.segment_valid = ro_seg_ff;
   assign rsp_bus.last_segment  = ro_last_ff;
   assign rsp_bus.merge_total   = ro_mt_ff;
   assign rsp_bus.dropped_flag  = ro_drop_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count beyond table depth");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> (i_ff < j_ff) && (CW'(j_ff) < cnt_ff))
      else $error("pair scan indices out of order");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EOUT) && out_free && last_k) |=> (cnt_ff == '0) && (merges_ff == '0))
      else $error("table not emptied after final result");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

endmodule

// ===== design/collinear_segment_merge_core.sv =====
// Top level of the collinear segment merge core: register port, intake and engine.
//
//  channel  | dir | handshake          | carries
//  req_bus  | in  | valid/ready        | command, start_x, start_y, end_x, end_y
//  rsp_bus  | out | valid/ready        | endpoints, segment_valid, last_segment, merge_total,
//           |     |                    | dropped_flag
//  csr_*    | in  | APB, pready high   | tolerance at byte address 0
//
// A non-vertical load is line-fitted in the engine through the bit-serial slope divider.
// A finish scans pairs, re-fits each merged segment through the divider, and compacts the
// table; emission then reads the results from the table and sends them one at a time.
// Reset is synchronous; it empties the table and restores tolerance to 66.
// A two-entry request queue keeps intake running while the engine or result side stalls, until it is full.
module collinear_segment_merge_core
   import csm_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   csm_req_if.sink                  req_bus,
   csm_rsp_if.source                rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);
   logic [TOL_BITS-1:0] tol_ff, tol_in;
   logic                csr_wr;
   q_ctl_type           q_ctl;
   logic signed [COORD_BITS-1:0] q_ax, q_ay, q_bx, q_by;
   logic signed [COORD_BITS:0]   q_dx, q_dy;
   logic                q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tol_in = tol_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_TOLERANCE)) begin
         tol_in = csr_pwdata[TOL_BITS-1:0];
      end
      csr_prdata = (csr_paddr[2] == CSR_IDX_TOLERANCE) ?
                   CSR_DATA_BITS'(tol_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   csm_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_ctl   (q_ctl),
      .q_ax    (q_ax),
      .q_ay    (q_ay),
      .q_bx    (q_bx),
      .q_by    (q_by),
      .q_dx    (q_dx),
      .q_dy    (q_dy),
      .q_pop   (q_pop)
   );

   csm_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .q_ctl     (q_ctl),
      .q_ax      (q_ax),
      .q_ay      (q_ay),
      .q_bx      (q_bx),
      .q_by      (q_by),
      .q_dx      (q_dx),
      .q_dy      (q_dy),
      .q_pop     (q_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== verif/tb_collinear_segment_merge_core.sv =====
// Testbench of the collinear segment merge core: directed and random segment sets, checked live.
module tb_collinear_segment_merge_core;
   import csm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB       = COORD_BITS_DEF;
   localparam int TABLE_SZ = MAX_SEGMENTS_DEF;
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;
   localparam longint CMIN = -(64'sd1 <<< (CB - 1));
   localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;

   typedef struct {
      logic signed [CB-1:0] sx, sy, ex, ey;
      logic                 present, last;
      logic [5:0]           merges;
      logic                 dropped;
   } seg_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   csm_req_if #(.CB(CB)) req_bus ();
   csm_rsp_if #(.CB(CB)) rsp_bus ();

   collinear_segment_merge_core dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end

   // predictor state
   longint tab_ax[TABLE_SZ], tab_ay[TABLE_SZ], tab_bx[TABLE_SZ], tab_by[TABLE_SZ];
   int     tab_count = 0;
   int     merge_tally = 0;
   bit     overflow_pending = 0;
   longint tol_now = 66;

   seg_result_type segments_due[$];
   int  error_count = 0;
   int  requests_sent = 0;
   int  results_seen = 0;
   int  merges_seen = 0;
   int  hold_request = 0;
   int  hold_count = 0;
   int  stall_left = 0;
   bit  quiet = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOAD;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit fit_line(int i, output longint m, output longint b);
      longint dx, dy;
      dx = tab_bx[i] - tab_ax[i];
      dy = tab_by[i] - tab_ay[i];
      m = 0;
      b = 0;
      if (dx == 0) return 0;
      m = clamp32((dy * 65536) / dx);
      b = clamp32(tab_ay[i] * 256 - (m * tab_ax[i]) / 256);
      return 1;
   endfunction

   function automatic bit near(longint a, longint c);
      longint d;
      d = a - c;
      if (d < 0) d = -d;
      return d < tol_now;
   endfunction

   function automatic bit joinable(int i, int j);
      longint m1, b1, m2, b2, pmax, pmin, qmax, qmin;
      if (!fit_line(i, m1, b1) || !fit_line(j, m2, b2)) return 0;
      if (!near(m1, m2) || !near(b1, b2)) return 0;
      pmax = tab_ax[i] > tab_bx[i] ? tab_ax[i] : tab_bx[i];
      pmin = tab_ax[i] < tab_bx[i] ? tab_ax[i] : tab_bx[i];
      qmax = tab_ax[j] > tab_bx[j] ? tab_ax[j] : tab_bx[j];
      qmin = tab_ax[j] < tab_bx[j] ? tab_ax[j] : tab_bx[j];
      return pmax >= qmin && qmax >= pmin;
   endfunction

   function automatic bit point_below(longint x1, longint y1, longint x2, longint y2);
      return (x1 < x2) || (x1 == x2 && y1 < y2);
   endfunction

   function automatic bit join_first_pair();
      longint xs[4], ys[4];
      longint nax[TABLE_SZ], nay[TABLE_SZ], nbx[TABLE_SZ], nby[TABLE_SZ];
      int lo, hi, w;
      for (int i = 0; i < tab_count; i++) begin
         for (int j = i + 1; j < tab_count; j++) begin
            if (joinable(i, j)) begin
               xs = '{tab_ax[i], tab_bx[i], tab_ax[j], tab_bx[j]};
               ys = '{tab_ay[i], tab_by[i], tab_ay[j], tab_by[j]};
               lo = 0;
               hi = 0;
               for (int k = 1; k < 4; k++) begin
                  if (point_below(xs[k], ys[k], xs[lo], ys[lo])) lo = k;
                  if (point_below(xs[hi], ys[hi], xs[k], ys[k])) hi = k;
               end
               w = 0;
               for (int k = 0; k < tab_count; k++) begin
                  if (k != i && k != j) begin
                     nax[w] = tab_ax[k]; nay[w] = tab_ay[k];
                     nbx[w] = tab_bx[k]; nby[w] = tab_by[k];
                     w++;
                  end
               end
               nax[w] = xs[lo]; nay[w] = ys[lo];
               nbx[w] = xs[hi]; nby[w] = ys[hi];
               tab_ax = nax; tab_ay = nay; tab_bx = nbx; tab_by = nby;
               tab_count = w + 1;
               if (merge_tally < 63) merge_tally++;
               return 1;
            end
         end
      end
      return 0;
   endfunction

   task automatic predict_request(logic cmd, logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                  logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
      seg_result_type r;
      if (cmd == CMD_LOAD) begin
         if (tab_count < TABLE_SZ) begin
            tab_ax[tab_count] = longint'(sx);
            tab_ay[tab_count] = longint'(sy);
            tab_bx[tab_count] = longint'(ex);
            tab_by[tab_count] = longint'(ey);
            tab_count++;
         end else begin
            overflow_pending = 1;
         end
         return;
      end
      while (join_first_pair()) begin
      end
      merges_seen += merge_tally;
      if (tab_count == 0) begin
         r = '{sx: '0, sy: '0, ex: '0, ey: '0, present: 1'b0, last: 1'b1, merges: '0,
               dropped: overflow_pending};
         segments_due.push_back(r);
      end
      for (int k = 0; k < tab_count; k++) begin
         r.sx = tab_ax[k][CB-1:0];
         r.sy = tab_ay[k][CB-1:0];
         r.ex = tab_bx[k][CB-1:0];
         r.ey = tab_by[k][CB-1:0];
         r.present = 1'b1;
         r.last = (k + 1 == tab_count);
         r.merges = r.last ? merge_tally[5:0] : 6'd0;
         r.dropped = overflow_pending;
         segments_due.push_back(r);
      end
      tab_count = 0;
      merge_tally = 0;
      overflow_pending = 0;
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch in result %0d, %s: got %0d, expected %0d", results_seen, field, got,
               want);
      error_count++;
   endtask

   always @(posedge clock) begin
      seg_result_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (segments_due.size() == 0) begin
            $display("result %0d arrived with nothing expected", results_seen);
            error_count++;
         end else begin
            w = segments_due.pop_front();
            if (rsp_bus.out_start_x !== w.sx)
               report_mismatch("out_start_x", rsp_bus.out_start_x, w.sx);
            if (rsp_bus.out_start_y !== w.sy)
               report_mismatch("out_start_y", rsp_bus.out_start_y, w.sy);
            if (rsp_bus.out_end_x !== w.ex)
               report_mismatch("out_end_x", rsp_bus.out_end_x, w.ex);
            if (rsp_bus.out_end_y !== w.ey)
               report_mismatch("out_end_y", rsp_bus.out_end_y, w.ey);
            if (rsp_bus.segment_valid !== w.present)
               report_mismatch("segment_valid", rsp_bus.segment_valid, w.present);
            if (rsp_bus.last_segment !== w.last)
               report_mismatch("last_segment", rsp_bus.last_segment, w.last);
            if (rsp_bus.merge_total !== w.merges)
               report_mismatch("merge_total", rsp_bus.merge_total, w.merges);
            if (rsp_bus.dropped_flag !== w.dropped)
               report_mismatch("dropped_flag", rsp_bus.dropped_flag, w.dropped);
         end
         results_seen++;
      end
      if (hold_request > 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_count--;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) < 2) begin
         rsp_bus.ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_request(logic cmd, logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                               logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 9) < 3)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x <= ex;
      req_bus.end_y <= ey;
      do @(posedge clock); while (!req_bus.ready);
      predict_request(cmd, sx, sy, ex, ey);
      requests_sent++;
   endtask

   task automatic load(longint sx, longint sy, longint ex, longint ey);
      send_request(CMD_LOAD, sx[CB-1:0], sy[CB-1:0], ex[CB-1:0], ey[CB-1:0]);
   endtask

   task automatic finish_set();
      send_request(CMD_FINISH, CB'($urandom()), CB'($urandom()), CB'($urandom()),
                   CB'($urandom()));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(CSR_IDX_TOLERANCE) << 2;
      csr_pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      tol_now = value;
   endtask

   // a run of segments along one line, some overlapping, touching or apart, plus noise
   task automatic load_line_set(int n);
      longint x0, y0, s, a, c, t;
      s = longint'($urandom_range(0, 6)) - 3;
      x0 = longint'($urandom_range(0, 2097152)) - 1048576;
      y0 = longint'($urandom_range(0, 2097152)) - 1048576;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            load($urandom(), $urandom(), $urandom(), $urandom());
         end else begin
            a = x0 + longint'($urandom_range(0, 4000));
            c = a + longint'($urandom_range(1, 1500));
            if ($urandom_range(0, 1)) begin
               t = a; a = c; c = t;
            end
            load(a, y0 + s * a, c, y0 + s * c);
         end
      end
   endtask

   task automatic test_directed();
      finish_set();
      load(CMIN, CMIN, CMAX, CMAX);
      load(CMAX, CMIN, CMIN, CMAX);
      load(CMIN, CMAX, CMIN, CMIN);
      load(0, 0, 0, 0);
      finish_set();
      load(0, 256, 0, 1024);
      load(0, 512, 0, 2048);
      load(256, 256, 1024, 1024);
      load(512, 512, 2048, 2048);
      load(4096, 256, 2048, 256);
      load(6144, 256, 4096, 256);
      load(10000, 256, 9000, 256);
      finish_set();
      load(0, 0, 256, 512);
      load(768, 1536, 512, 1024);
      load(256, 512, 512, 1024);
      load(-256, 100, 256, 100);
      load(-256, -100, 256, -100);
      finish_set();
      drain();
   endtask

   task automatic test_overflow();
      for (int k = 0; k < TABLE_SZ + 3; k++) load(k * 64, k * 2560, k * 64 + 100, k * 2560);
      finish_set();
      load(0, 0, 256, 0);
      finish_set();
      drain();
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      load_line_set(5);
      finish_set();
      load_line_set(4);
      finish_set();
      load_line_set(3);
      finish_set();
      drain();
   endtask

   task automatic test_random_sets(int sets);
      int n;
      for (int q = 0; q < sets; q++) begin
         quiet = ($urandom_range(0, 5) == 0);
         n = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
         load_line_set(n);
         finish_set();
      end
      quiet = 0;
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random_sets(12);
      write_tolerance(16'd0);
      test_random_sets(6);
      write_tolerance(16'hffff);
      test_random_sets(6);
      write_tolerance(16'd1);
      test_random_sets(6);
      write_tolerance($urandom_range(2, 65534));
      test_random_sets(6);
      write_tolerance(16'd66);
      while (requests_sent < 360) test_random_sets(4);
      $display("covered %0d requests, %0d results, %0d merges, tolerance 0 to 65535,",
               requests_sent, results_seen, merges_seen);
      $display("table overflow, empty finishes and a long result-side hold");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
